@@ src/utf8_stream_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder_macros.svh
// Assertion macros for the UTF-8 stream decoder. Compile with NO_ASSERTIONS
// defined to drop every check.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, disabled while reset is asserted
`define UTF8SD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define UTF8SD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define UTF8SD_ASSERT(lbl, clk, rst_n, prop, msg)
`define UTF8SD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ src/utf8sd_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Types and constants shared by the UTF-8 stream decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package utf8sd_pkg;

	localparam int unsigned CP_W  = 21;
	localparam int unsigned LEN_W = 3;

	localparam logic [CP_W-1:0]  REPLACEMENT = 21'h00FFFD;
	localparam logic [CP_W-1:0]  MIN_LEN2    = 21'h000080;
	localparam logic [CP_W-1:0]  MIN_LEN3    = 21'h000800;
	localparam logic [CP_W-1:0]  MIN_LEN4    = 21'h010000;

	localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
	localparam logic [LEN_W-1:0] LEN_1    = 3'd1;
	localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
	localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
	localparam logic [LEN_W-1:0] LEN_4    = 3'd4;

	// Following bytes still expected
	localparam logic [1:0] LEFT_NONE = 2'd0;
	localparam logic [1:0] LEFT_1    = 2'd1;
	localparam logic [1:0] LEFT_2    = 2'd2;
	localparam logic [1:0] LEFT_3    = 2'd3;

	// Result handed from the decode core to the output register
	typedef struct packed {
		logic             valid;
		logic [CP_W-1:0]  code_point;
		logic [LEN_W-1:0] seq_bytes;
	} res_t;

	// Smallest legal value for a sequence of the given length
	function automatic logic [CP_W-1:0] min_for_len(input logic [LEN_W-1:0] len);
		logic [CP_W-1:0] m;
		case (len)
			LEN_2:   m = MIN_LEN2;
			LEN_3:   m = MIN_LEN3;
			LEN_4:   m = MIN_LEN4;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

@@ src/utf8sd_in_stage.sv @@
// ----------------------------------------------------------------------------
// utf8sd_in_stage
// Input register: holds one accepted byte until the decode stage takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8sd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	// Free when empty or when the held byte moves on this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

@@ src/utf8sd_core.sv @@
// ----------------------------------------------------------------------------
// utf8sd_core
// Sequence state and per-byte decode; yields at most one result per byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8sd_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          byte_s1,
	output utf8sd_pkg::res_t    res
);

	import utf8sd_pkg::*;

	logic [1:0]       bytes_left_q, bytes_left_d;
	logic [CP_W-1:0]  accum_q, accum_d;
	logic [LEN_W-1:0] seq_len_q, seq_len_d;
	logic             poisoned_q, poisoned_d;

	logic             is_cont;
	logic [CP_W-1:0]  cp_raw;

	assign is_cont = (byte_s1[7:6] == 2'b10);

	// Next state and result for the byte in the input register
	always_comb begin
		bytes_left_d = bytes_left_q;
		accum_d      = accum_q;
		seq_len_d    = seq_len_q;
		poisoned_d   = poisoned_q;
		cp_raw       = accum_q;
		res.valid      = 1'b0;
		res.code_point = REPLACEMENT;
		res.seq_bytes  = LEN_1;

		if (bytes_left_q == LEFT_NONE) begin
			if (!byte_s1[7]) begin
				// plain ASCII
				res.valid      = 1'b1;
				res.code_point = {13'd0, byte_s1};
			end else if (!byte_s1[6]) begin
				// stray continuation
				res.valid = 1'b1;
			end else begin
				poisoned_d = 1'b0;
				if (byte_s1[5:4] == 2'b11) begin
					accum_d      = {18'd0, byte_s1[2:0]};
					bytes_left_d = LEFT_3;
					seq_len_d    = LEN_4;
				end else if (byte_s1[5]) begin
					accum_d      = {17'd0, byte_s1[3:0]};
					bytes_left_d = LEFT_2;
					seq_len_d    = LEN_3;
				end else begin
					accum_d      = {16'd0, byte_s1[4:0]};
					bytes_left_d = LEFT_1;
					seq_len_d    = LEN_2;
				end
			end
		end else begin
			// following byte: always consumed, malformed ones poison
			if (!is_cont) begin
				poisoned_d = 1'b1;
			end else if (!poisoned_q) begin
				accum_d = {accum_q[CP_W-7:0], byte_s1[5:0]};
			end
			bytes_left_d = bytes_left_q - 2'd1;

			if (bytes_left_d == LEFT_NONE) begin
				// value of the finished sequence, taken before the state clears
				cp_raw         = poisoned_d ? REPLACEMENT : accum_d;
				res.valid      = 1'b1;
				res.seq_bytes  = seq_len_q;
				// overlong forms fall back to the replacement
				res.code_point = (cp_raw < min_for_len(seq_len_q)) ? REPLACEMENT : cp_raw;
				accum_d        = '0;
				seq_len_d      = LEN_NONE;
				poisoned_d     = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= LEFT_NONE;
			accum_q      <= '0;
			seq_len_q    <= LEN_NONE;
			poisoned_q   <= 1'b0;
		end else if (advance) begin
			bytes_left_q <= bytes_left_d;
			accum_q      <= accum_d;
			seq_len_q    <= seq_len_d;
			poisoned_q   <= poisoned_d;
		end
	end

endmodule

@@ src/utf8sd_out_stage.sv @@
// ----------------------------------------------------------------------------
// utf8sd_out_stage
// Result register: holds one code point until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8sd_out_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  utf8sd_pkg::res_t              res,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [utf8sd_pkg::CP_W-1:0]   code_point,
	output logic [utf8sd_pkg::LEN_W-1:0]  seq_bytes
);

	import utf8sd_pkg::*;

	// advance is only raised when the slot is empty or being emptied
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= res.valid;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			code_point <= res.code_point;
			seq_bytes  <= res.seq_bytes;
		end
	end

endmodule

@@ src/utf8_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial UTF-8 decoder: one byte in per item, one code point out when
// a sequence completes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one raw byte (in_byte) per item.
//   Output channel out_valid/out_ready carries code_point and seq_bytes.
//   ASCII and stray continuation bytes give a result for the same item;
//   lead bytes open a sequence whose result comes with its last byte.
//   Invalid, poisoned or overlong sequences give 0xFFFD.
//   Throughput: one byte per cycle while the receiver keeps out_ready high,
//   set by the single decode stage that updates the sequence state on advance.
//   Path: the last byte of a sequence is held in the input register, then its
//   result is captured in the result register, which drives the output; a
//   stall on the output keeps the byte waiting in the input register.
//   Reset (arst_n low) empties both registers and closes any open sequence.
//   When the receiver stalls, the result register holds its item and decode
//   stops; an empty input register still takes one more byte, then in_ready
//   drops until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "utf8_stream_decoder_macros.svh"

module utf8_stream_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    in_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [utf8sd_pkg::CP_W-1:0]   code_point,
	output logic [utf8sd_pkg::LEN_W-1:0]  seq_bytes
);

	import utf8sd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	res_t       res;

	logic       len_ok;
	logic       one_ok;
	logic       two_ok;

	// The held byte moves through decode when the result slot can take it
	assign advance = valid_s1 && (!out_valid || out_ready);

	utf8sd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	utf8sd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	utf8sd_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.res        (res),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.code_point (code_point),
		.seq_bytes  (seq_bytes)
	);

	// Result range terms used by the checks
	assign len_ok = (seq_bytes == LEN_1) || (seq_bytes == LEN_2) ||
			(seq_bytes == LEN_3) || (seq_bytes == LEN_4);
	assign one_ok = (code_point < MIN_LEN2) || (code_point == REPLACEMENT);
	assign two_ok = ((code_point >= MIN_LEN2) && (code_point < MIN_LEN3)) ||
			(code_point == REPLACEMENT);

	// Checks
	`UTF8SD_ASSERT(a_len_range, clk, arst_n, out_valid |-> len_ok, "seq_bytes out of range")
	`UTF8SD_ASSERT(a_single_byte, clk, arst_n, (out_valid && seq_bytes == LEN_1) |-> one_ok, "bad single-byte result")
	`UTF8SD_ASSERT(a_two_byte, clk, arst_n, (out_valid && seq_bytes == LEN_2) |-> two_ok, "bad two-byte result")
	`UTF8SD_ASSERT(a_stall_hold, clk, arst_n, (out_valid && !out_ready) |-> !advance, "decode moved while stalled")
	`UTF8SD_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> (!out_valid && !valid_s1), "not empty after reset")

endmodule
